>>> hw/rtl/psfs_pkg.sv
// Package for the panel SPI frame serializer.
// Holds the payload structs, the command struct and the register indexes.
// No dependencies.
package psfs_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned BitIdxW   = $clog2(FrameBits);

  localparam logic [CfgIdxW-1:0] RegIndexStart = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDataStart  = 1'b1;

  localparam logic [ByteBits-1:0] IndexStartRst = 8'h70;
  localparam logic [ByteBits-1:0] DataStartRst  = 8'h72;

  typedef enum logic {
    OP_REG_WRITE  = 1'b0,
    OP_DATA_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] payload;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_start;
    logic frame_end;
    logic last_bit;
  } out_item_t;

  typedef struct packed {
    logic                 two_frames;
    logic [FrameBits-1:0] index_word;
    logic [FrameBits-1:0] data_word;
  } frame_cmd_t;

endpackage

>>> hw/rtl/panel_spi_frame_serializer.sv
// Panel SPI frame serializer, top level: turns one panel command into 16 or 32
// MSB-first serial bits with frame marks. Depends on psfs_pkg, psfs_cfg_regs,
// psfs_cmd_buf and psfs_serializer.
//
// A register write (operation 0) produces two 16-bit frames, the index start
// byte with the high payload byte and then the data start byte with the low
// payload byte; a data write (operation 1) produces only the second frame.
// One bit transfer leaves per cycle while the output is not stalled; a register
// write shifts out 32 bits and a data write 16 bits from the single shift register.
// A one-command input register takes the next command while the current one
// is still shifting out, and bits of consecutive commands follow without gap.
// The start byte registers reset to 0x70 and 0x72; they are sampled when a
// command is taken and should be written only while the block is idle.
module panel_spi_frame_serializer
  import psfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  logic [ByteBits-1:0] index_start;
  logic [ByteBits-1:0] data_start;
  logic                cmd_valid;
  logic                cmd_take;
  frame_cmd_t          cmd;

  psfs_cfg_regs u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .index_start_o (index_start),
    .data_start_o  (data_start)
  );

  psfs_cmd_buf u_cmd_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .index_start_i (index_start),
    .data_start_i  (data_start),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  psfs_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> hw/rtl/psfs_cfg_regs.sv
// Start byte registers of the panel SPI frame serializer.
// Depends on psfs_pkg.
module psfs_cfg_regs
  import psfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [ByteBits-1:0] index_start_o,
  output logic [ByteBits-1:0] data_start_o
);

  logic [ByteBits-1:0] index_start_q, index_start_d;
  logic [ByteBits-1:0] data_start_q, data_start_d;

  always_comb begin
    index_start_d = index_start_q;
    data_start_d  = data_start_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIndexStart: index_start_d = cfg_data_i;
        RegDataStart:  data_start_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_start_q <= IndexStartRst;
      data_start_q  <= DataStartRst;
    end else begin
      index_start_q <= index_start_d;
      data_start_q  <= data_start_d;
    end
  end

  assign index_start_o = index_start_q;
  assign data_start_o  = data_start_q;

endmodule

>>> hw/rtl/psfs_cmd_buf.sv
// Input register of the panel SPI frame serializer: builds both frame words.
// Depends on psfs_pkg.
module psfs_cmd_buf
  import psfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  input  logic [ByteBits-1:0] index_start_i,
  input  logic [ByteBits-1:0] data_start_i,
  output logic                cmd_valid_o,
  output frame_cmd_t          cmd_o,
  input  logic                cmd_take_i
);

  logic       valid_q, valid_d;
  frame_cmd_t cmd_q, cmd_d;
  logic       accept;

  assign in_stall_o = valid_q;
  assign accept     = in_valid_i && !valid_q;

  always_comb begin
    cmd_d            = cmd_q;
    cmd_d.two_frames = (op_e'(in_item_i.operation) == OP_REG_WRITE);
    cmd_d.index_word = {index_start_i, in_item_i.payload[15:8]};
    cmd_d.data_word  = {data_start_i, in_item_i.payload[7:0]};
    if (!accept) begin
      cmd_d = cmd_q;
    end
    valid_d = accept || (valid_q && !cmd_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hw/rtl/psfs_serializer.sv
// Bit serializer of the panel SPI frame serializer: a 32-bit shift register
// whose top bit and bit counter form the output register. Depends on psfs_pkg.
module psfs_serializer
  import psfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  frame_cmd_t cmd_i,
  output logic       cmd_take_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic                   busy_q, busy_d;
  logic                   final_q, final_d;
  logic [BitIdxW-1:0]     bit_idx_q, bit_idx_d;
  logic [2*FrameBits-1:0] shift_q, shift_d;
  logic                   advance;
  logic                   frame_end;
  logic                   run_end;

  assign frame_end  = (bit_idx_q == BitIdxW'(FrameBits - 1));
  assign run_end    = frame_end && final_q;
  assign advance    = busy_q && !out_stall_i;
  assign cmd_take_o = cmd_valid_i && (!busy_q || (advance && run_end));

  always_comb begin
    busy_d    = busy_q;
    final_d   = final_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    if (cmd_take_o) begin
      busy_d    = 1'b1;
      bit_idx_d = '0;
      if (cmd_i.two_frames) begin
        shift_d = {cmd_i.index_word, cmd_i.data_word};
        final_d = 1'b0;
      end else begin
        shift_d = {cmd_i.data_word, {FrameBits{1'b0}}};
        final_d = 1'b1;
      end
    end else if (advance) begin
      if (run_end) begin
        busy_d = 1'b0;
      end else begin
        shift_d   = {shift_q[2*FrameBits-2:0], 1'b0};
        bit_idx_d = bit_idx_q + BitIdxW'(1);
        if (frame_end) begin
          final_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      final_q   <= 1'b0;
      bit_idx_q <= '0;
    end else begin
      busy_q    <= busy_d;
      final_q   <= final_d;
      bit_idx_q <= bit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign out_valid_o            = busy_q;
  assign out_item_o.serial_bit  = shift_q[2*FrameBits-1];
  assign out_item_o.frame_start = (bit_idx_q == '0);
  assign out_item_o.frame_end   = frame_end;
  assign out_item_o.last_bit    = run_end;

endmodule
